// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by the controller, the datapath and the top level; no dependencies.
package spq_pkg;

    localparam int VALUE_W           = 32;
    localparam int PRIO_PORT_W       = 8;
    localparam int STATUS_W          = 2;
    localparam int HELD_W            = 4;
    localparam int PRIO_WIDE_W       = 40;
    localparam int DEF_QUEUE_DEPTH   = 8;
    localparam int DEF_PRIORITY_BITS = 8;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                ins;
        logic                rem;
        logic                load;
        logic [STATUS_W-1:0] status;
    } spq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

// ===== sv/spq_ctrl.sv =====
// Request controller for the sorted priority queue: handshake and command decode.
// Depends on spq_pkg for the command and status structs and the codes.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      kind,
    output logic      out_valid,
    input  logic      out_ready,
    input  spq_stat_t dp_stat,
    output spq_cmd_t  dp_cmd
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_HOLD = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE) || out_ready;
    assign out_valid = (state_reg == S_HOLD);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!accept && out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        dp_cmd.load   = accept;
        dp_cmd.ins    = 1'b0;
        dp_cmd.rem    = 1'b0;
        dp_cmd.status = STATUS_DONE;
        if (kind == KIND_INSERT)
        begin
            if (dp_stat.full)
            begin
                dp_cmd.status = STATUS_FULL;
            end
            else
            begin
                dp_cmd.ins = accept;
            end
        end
        else
        begin
            if (dp_stat.empty)
            begin
                dp_cmd.status = STATUS_EMPTY;
            end
            else
            begin
                dp_cmd.rem = accept;
            end
        end
    end

endmodule

// ===== sv/spq_datapath.sv =====
// Datapath of the sorted priority queue: the slot row with parallel compare and shift,
// the entry count and the result register. Depends on spq_pkg.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  spq_cmd_t                      dp_cmd,
    output spq_stat_t                     dp_stat,
    input  logic signed [VALUE_W-1:0]     item_value,
    input  logic        [PRIO_PORT_W-1:0] item_priority,
    output logic signed [VALUE_W-1:0]     out_value,
    output logic        [PRIO_PORT_W-1:0] out_priority,
    output logic        [STATUS_W-1:0]    status,
    output logic        [HELD_W-1:0]      entries_held
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int HW = (CW > HELD_W) ? CW : HELD_W;

    logic [VALUE_W-1:0]       slot_val_reg  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] slot_pri_reg  [QUEUE_DEPTH];
    logic [VALUE_W-1:0]       slot_val_next [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] slot_pri_next [QUEUE_DEPTH];
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;

    logic [QUEUE_DEPTH-1:0]   move_down;
    logic [QUEUE_DEPTH-1:0]   ins_here;
    logic [PRIO_WIDE_W-1:0]   pri_in_wide;
    logic [PRIORITY_BITS-1:0] pri_in;
    logic [PRIO_WIDE_W-1:0]   pri_out_wide;
    logic [HW-1:0]            held_wide;

    logic signed [VALUE_W-1:0]     out_value_reg;
    logic        [PRIO_PORT_W-1:0] out_priority_reg;
    logic        [STATUS_W-1:0]    status_reg;
    logic        [HELD_W-1:0]      held_reg;

    assign pri_in_wide  = {{(PRIO_WIDE_W - PRIO_PORT_W){1'b0}}, item_priority};
    assign pri_in       = pri_in_wide[PRIORITY_BITS-1:0];
    assign pri_out_wide = {{(PRIO_WIDE_W - PRIORITY_BITS){1'b0}}, slot_pri_reg[0]};

    assign dp_stat.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign dp_stat.empty = (count_reg == '0);

    // Entries of lower priority than the new one form a suffix of the occupied slots.
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            move_down[i] = (CW'(i) < count_reg) && (slot_pri_reg[i] < pri_in);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            ins_here[i] = ((i == 0) || !move_down[(i == 0) ? 0 : i - 1])
                          && (move_down[i] || (CW'(i) == count_reg));
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_val_next[i] = slot_val_reg[i];
            slot_pri_next[i] = slot_pri_reg[i];
            if (dp_cmd.ins)
            begin
                if (ins_here[i])
                begin
                    slot_val_next[i] = item_value;
                    slot_pri_next[i] = pri_in;
                end
                else if ((i > 0) && move_down[(i == 0) ? 0 : i - 1])
                begin
                    slot_val_next[i] = slot_val_reg[(i == 0) ? 0 : i - 1];
                    slot_pri_next[i] = slot_pri_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (dp_cmd.rem && (i < QUEUE_DEPTH - 1))
            begin
                slot_val_next[i] = slot_val_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                slot_pri_next[i] = slot_pri_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (dp_cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (dp_cmd.rem)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign held_wide = {{(HW - CW){1'b0}}, count_next};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_val_reg[i] <= slot_val_next[i];
            slot_pri_reg[i] <= slot_pri_next[i];
        end
        if (dp_cmd.load)
        begin
            out_value_reg    <= dp_cmd.rem ? signed'(slot_val_reg[0]) : '0;
            out_priority_reg <= dp_cmd.rem ? pri_out_wide[PRIO_PORT_W-1:0] : '0;
            status_reg       <= dp_cmd.status;
            held_reg         <= held_wide[HELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign out_value    = out_value_reg;
    assign out_priority = out_priority_reg;
    assign status       = status_reg;
    assign entries_held = held_reg;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue of QUEUE_DEPTH entries, highest priority at the front and
// equal priorities served in arrival order. The whole slot row compares against the
// new priority and shifts in parallel, so a request is accepted each cycle as long as
// the result is taken. Each request gives exactly one result with the count held; a
// full insert or an empty remove reports its status and changes nothing. Top level;
// depends on spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic signed [VALUE_W-1:0]     item_value,
    input  logic        [PRIO_PORT_W-1:0] item_priority,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_W-1:0]     out_value,
    output logic        [PRIO_PORT_W-1:0] out_priority,
    output logic        [STATUS_W-1:0]    status,
    output logic        [HELD_W-1:0]      entries_held
);

    spq_cmd_t  dp_cmd;
    spq_stat_t dp_stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .status        (status),
        .entries_held  (entries_held)
    );

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("Accepted request produced no result.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FULL) |-> entries_held == HELD_W'(QUEUE_DEPTH))
        else $error("Full status without a full count.");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_EMPTY)
        |-> (entries_held == '0) && (out_value == '0) && (out_priority == '0))
        else $error("Empty status with nonzero result fields.");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the sorted priority queue: directed and random requests
// with random stalls on both channels, checked against an in-bench sorted-slot predictor.
// Depends on spq_pkg and sorted_priority_queue.
module tb_top;
    import spq_pkg::*;

    localparam int DEPTH      = DEF_QUEUE_DEPTH;
    localparam int PRIO_BITS  = DEF_PRIORITY_BITS;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic signed [VALUE_W-1:0]     value;
        logic        [PRIO_PORT_W-1:0] prio;
        logic        [STATUS_W-1:0]    status;
        logic        [HELD_W-1:0]      held;
    } queue_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          kind = KIND_INSERT;
    logic signed [VALUE_W-1:0]     item_value = '0;
    logic        [PRIO_PORT_W-1:0] item_priority = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [VALUE_W-1:0]     out_value;
    logic        [PRIO_PORT_W-1:0] out_priority;
    logic        [STATUS_W-1:0]    status;
    logic        [HELD_W-1:0]      entries_held;

    logic signed [VALUE_W-1:0]     slot_value_q [DEPTH];
    logic        [PRIO_PORT_W-1:0] slot_prio_q  [DEPTH];
    int                            held_count = 0;

    queue_result_t pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int results_checked = 0;
    int requests_sent = 0;
    int inserts_done = 0;
    int inserts_refused = 0;
    int removes_done = 0;
    int removes_empty = 0;
    int quiet_cycles = 0;

    sorted_priority_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .status        (status),
        .entries_held  (entries_held)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic queue_result_t queue_apply(input logic k,
                                                  input logic signed [VALUE_W-1:0] v,
                                                  input logic [PRIO_PORT_W-1:0] p);
        queue_result_t r;
        logic [PRIO_PORT_W-1:0] pri;
        int pos;
        r = '0;
        pri = p & PRIO_PORT_W'((64'd1 << PRIO_BITS) - 1);
        if (k == KIND_INSERT)
        begin
            if (held_count >= DEPTH)
            begin
                r.status = STATUS_FULL;
                inserts_refused++;
            end
            else
            begin
                pos = held_count;
                while (pos > 0 && slot_prio_q[pos-1] < pri)
                begin
                    slot_value_q[pos] = slot_value_q[pos-1];
                    slot_prio_q[pos]  = slot_prio_q[pos-1];
                    pos--;
                end
                slot_value_q[pos] = v;
                slot_prio_q[pos]  = pri;
                held_count++;
                r.status = STATUS_DONE;
                inserts_done++;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                r.status = STATUS_EMPTY;
                removes_empty++;
            end
            else
            begin
                r.value = slot_value_q[0];
                r.prio  = slot_prio_q[0];
                for (int i = 1; i < held_count; i++)
                begin
                    slot_value_q[i-1] = slot_value_q[i];
                    slot_prio_q[i-1]  = slot_prio_q[i];
                end
                held_count--;
                r.status = STATUS_DONE;
                removes_done++;
            end
        end
        r.held = HELD_W'(held_count);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is accepted.
    task automatic send_request(input logic k, input logic signed [VALUE_W-1:0] v,
                                input logic [PRIO_PORT_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        item_value    <= v;
        item_priority <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(queue_apply(k, v, p));
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        queue_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("ERROR: unexpected result value=%0d prio=%0d status=%0d held=%0d",
                             out_value, out_priority, status, entries_held);
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_value !== exp_r.value || out_priority !== exp_r.prio ||
                    status !== exp_r.status || entries_held !== exp_r.held)
                begin
                    if (mismatches < 10)
                        $display("ERROR: result %0d expected value=%0d prio=%0d status=%0d ",
                                 results_checked, exp_r.value, exp_r.prio, exp_r.status,
                                 "held=%0d, got value=%0d prio=%0d status=%0d held=%0d",
                                 exp_r.held, out_value, out_priority, status, entries_held);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("** sorted_priority_queue: FAILED **");
                $finish;
            end
        end
    end

    // An empty remove, then min value at priority 0 and max value at 255, drained in order.
    task automatic test_extremes();
        send_request(KIND_REMOVE, 32'sh7fffffff, 8'hff);
        send_request(KIND_INSERT, 32'sh80000000, 8'd0);
        send_request(KIND_INSERT, 32'sh7fffffff, 8'd255);
        send_request(KIND_INSERT, 32'sd0, 8'd128);
        send_request(KIND_INSERT, -32'sd1, 8'd255);
        repeat (4) send_request(KIND_REMOVE, $urandom, 8'($urandom));
    endtask

    // Equal priorities must leave in arrival order; a full queue refuses further inserts.
    task automatic test_ties_and_full();
        logic [PRIO_PORT_W-1:0] prios [8];
        prios = '{8'd5, 8'd5, 8'd9, 8'd5, 8'd9, 8'd0, 8'd9, 8'd5};
        for (int i = 0; i < 8; i++)
            send_request(KIND_INSERT, 32'(i + 100), prios[i]);
        send_request(KIND_INSERT, 32'sh55aa55aa, 8'd255);
        repeat (8) send_request(KIND_REMOVE, 32'sd0, 8'd0);
    endtask

    // Bursts lean toward filling, draining or balance so that full and empty recur often.
    task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
        int mode;
        int ins_pct;
        int sel;
        logic k;
        logic signed [VALUE_W-1:0] v;
        logic [PRIO_PORT_W-1:0] p;
        mode = 2;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 16 == 0)
                mode = $urandom_range(2);
            ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            k = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
            sel = $urandom_range(9);
            if (sel == 0)
                v = 32'sh80000000;
            else if (sel == 1)
                v = 32'sh7fffffff;
            else
                v = $urandom;
            sel = $urandom_range(9);
            if (sel < 4)
                p = 8'($urandom_range(3));
            else if (sel == 4)
                p = 8'd0;
            else if (sel == 5)
                p = 8'd255;
            else
                p = 8'($urandom_range(255));
            send_request(k, v, p);
            if (i == n_items / 2)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 79;
        test_extremes();
        wait_for_results();
        test_ties_and_full();
        wait_for_results();

        test_random_traffic(700, 36, 79);
        test_random_traffic(700, 79, 36);
        test_random_traffic(600, 0, 0);

        repeat (8) @(negedge clk);
        mismatches += pending_results.size();

        $display("Sent %0d requests: %0d inserts stored, %0d refused as full, ",
                 requests_sent, inserts_done, inserts_refused,
                 "%0d removes done, %0d on empty.", removes_done, removes_empty);
        $display("Checked %0d results under three stall mixes; %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("** sorted_priority_queue: PASSED **");
        else
            $display("** sorted_priority_queue: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue.sv
dv/tb_top.sv
